/* sv/mscr_pkg.sv */
`timescale 1ns / 1ps

package mscr_pkg;

    // Number of motor channels held in the state table
    localparam int CHANNELS = 4;
    localparam int CH_W     = 2;

    typedef logic signed [7:0] t_speed;
    typedef logic        [6:0] t_period;
    typedef logic        [1:0] t_run;

    // Item kinds
    typedef enum logic {
        KIND_REQ  = 1'b0,
        KIND_TICK = 1'b1
    } t_kind;

    // Running-type marker for a channel whose PWM was never started
    localparam t_run RUN_NONE = 2'd3;

    // Drive pin codes
    localparam logic [1:0] PIN_OFF = 2'd0;
    localparam logic [1:0] PIN_A   = 2'd1;
    localparam logic [1:0] PIN_B   = 2'd2;

endpackage

/* sv/motor_speed_ramp_controller.sv */
`timescale 1ns / 1ps

// Channel  | Direction | Handshake          | Payload
// ---------+-----------+--------------------+-----------------------------------------
// input    | in        | i_valid / o_stall  | kind, channel, target_speed, ramp_period,
//          |           |                    | coreless_flag, fault_active
// result   | out       | o_valid / i_stall  | out_channel, speed_now, drive_pin,
//          |           |                    | pulse_width, clock_select, pwm_restart
//
// One transaction per clock unless the result side stalls: input register,
// then one pass of per-channel compare/step logic into the result register.
// The channel state table is written at the same edge the result is
// registered, so an item for the same channel right behind sees it.
// Synchronous active-low reset clears the state table and both valid flags.
// A stalled result holds the pass; the input register still fills once.

module motor_speed_ramp_controller (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_stall,
    input  logic                    i_kind,
    input  logic [1:0]              i_channel,
    input  mscr_pkg::t_speed        i_target_speed,
    input  mscr_pkg::t_period       i_ramp_period,
    input  logic                    i_coreless_flag,
    input  logic                    i_fault_active,
    output logic                    o_valid,
    input  logic                    i_stall,
    output logic [1:0]              o_out_channel,
    output mscr_pkg::t_speed        o_speed_now,
    output logic [1:0]              o_drive_pin,
    output logic [7:0]              o_pulse_width,
    output logic                    o_clock_select,
    output logic                    o_pwm_restart
);
    import mscr_pkg::*;

    // Input register
    logic            r_in_valid;
    t_kind           r_kind;
    logic [CH_W-1:0] r_ch;
    t_speed          r_tgt;
    t_period         r_per;
    logic            r_type;
    logic            r_fault;

    // Per-channel state
    t_speed  r_cur  [CHANNELS];
    t_speed  r_stgt [CHANNELS];
    t_period r_sper [CHANNELS];
    logic    r_treq [CHANNELS];
    t_run    r_run  [CHANNELS];
    t_period r_tick [CHANNELS];
    t_speed  n_cur  [CHANNELS];
    t_speed  n_stgt [CHANNELS];
    t_period n_sper [CHANNELS];
    logic    n_treq [CHANNELS];
    t_run    n_run  [CHANNELS];
    t_period n_tick [CHANNELS];

    // Result register
    logic        r_out_valid;
    logic [1:0]  r_o_ch;
    t_speed      r_o_speed;
    logic [1:0]  r_o_pin;
    logic [7:0]  r_o_pw;
    logic        r_o_clk;
    logic        r_o_restart;

    logic        advance;
    logic        take_in;
    logic        ch_ok;
    t_speed      cur_rd;
    t_speed      tgt_rd;
    t_period     per_rd;
    logic        treq_rd;
    t_run        run_rd;
    t_period     tick_rd;
    t_speed      sp_new;
    t_run        run_new;
    logic        restart;
    logic        idle;
    logic [1:0]  pin_new;
    logic [7:0]  pw_new;
    logic        clk_new;

    // Handshake: the pass moves when the result register is free or drains
    assign advance = r_in_valid && (!r_out_valid || !i_stall);
    assign o_stall = r_in_valid && !advance;
    assign take_in = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (take_in) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take_in) begin
            r_kind  <= t_kind'(i_kind);
            r_ch    <= i_channel;
            r_tgt   <= i_target_speed;
            r_per   <= i_ramp_period;
            r_type  <= i_coreless_flag;
            r_fault <= i_fault_active;
        end
    end

    // State read for the addressed channel
    assign ch_ok   = (int'(r_ch) < CHANNELS);
    assign cur_rd  = r_cur[r_ch];
    assign tgt_rd  = r_stgt[r_ch];
    assign per_rd  = r_sper[r_ch];
    assign treq_rd = r_treq[r_ch];
    assign run_rd  = r_run[r_ch];
    assign tick_rd = r_tick[r_ch];

    // Request / tick step logic
    always_comb begin
        n_cur   = r_cur;
        n_stgt  = r_stgt;
        n_sper  = r_sper;
        n_treq  = r_treq;
        n_run   = r_run;
        n_tick  = r_tick;
        sp_new  = cur_rd;
        run_new = run_rd;
        restart = 1'b0;
        idle    = (cur_rd == tgt_rd) && ({1'b0, treq_rd} == run_rd);
        if (ch_ok) begin
            if (r_kind == KIND_REQ) begin
                n_stgt[r_ch] = r_tgt;
                n_sper[r_ch] = r_per;
                n_treq[r_ch] = r_type;
                if (!r_fault) begin
                    if (r_per == '0) begin
                        // immediate change
                        sp_new = r_tgt;
                        if (r_tgt != '0 && (cur_rd == '0 || {1'b0, r_type} != run_rd)) begin
                            restart = 1'b1;
                            run_new = {1'b0, r_type};
                        end
                    end else if (cur_rd == r_tgt && {1'b0, r_type} != run_rd) begin
                        // type change alone at a nonzero target: re-clock now
                        if (cur_rd != '0) begin
                            restart = 1'b1;
                            run_new = {1'b0, r_type};
                        end
                    end
                end
            end else begin
                if (!idle && !r_fault) begin
                    if (tick_rd >= per_rd) begin
                        n_tick[r_ch] = '0;
                        if (cur_rd != tgt_rd) begin
                            sp_new = (cur_rd < tgt_rd) ? t_speed'(cur_rd + 8'sd1)
                                                       : t_speed'(cur_rd - 8'sd1);
                            if (sp_new != '0 &&
                                (cur_rd == '0 || {1'b0, treq_rd} != run_rd)) begin
                                restart = 1'b1;
                                run_new = {1'b0, treq_rd};
                            end
                        end
                    end else begin
                        n_tick[r_ch] = t_period'(tick_rd + 7'd1);
                    end
                end
            end
            n_cur[r_ch] = sp_new;
            n_run[r_ch] = run_new;
        end
    end

    // Result decode
    always_comb begin
        if (!ch_ok) begin
            pin_new = PIN_OFF;
            pw_new  = '0;
            clk_new = 1'b0;
        end else begin
            if (sp_new > 0) begin
                pin_new = PIN_A;
            end else if (sp_new < 0) begin
                pin_new = PIN_B;
            end else begin
                pin_new = PIN_OFF;
            end
            pw_new  = (sp_new < 0) ? 8'(unsigned'(-sp_new)) : 8'(unsigned'(sp_new));
            clk_new = (run_new == RUN_NONE) ? 1'b0 : run_new[0];
        end
    end

    // Channel state table
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < CHANNELS; i++) begin
                r_cur[i]  <= '0;
                r_stgt[i] <= '0;
                r_sper[i] <= '0;
                r_treq[i] <= 1'b0;
                r_run[i]  <= RUN_NONE;
                r_tick[i] <= '0;
            end
        end else if (advance) begin
            r_cur  <= n_cur;
            r_stgt <= n_stgt;
            r_sper <= n_sper;
            r_treq <= n_treq;
            r_run  <= n_run;
            r_tick <= n_tick;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_o_ch      <= r_ch;
            r_o_speed   <= ch_ok ? sp_new : '0;
            r_o_pin     <= pin_new;
            r_o_pw      <= pw_new;
            r_o_clk     <= clk_new;
            r_o_restart <= ch_ok && restart;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_out_channel  = r_o_ch;
    assign o_speed_now    = r_o_speed;
    assign o_drive_pin    = r_o_pin;
    assign o_pulse_width  = r_o_pw;
    assign o_clock_select = r_o_clk;
    assign o_pwm_restart  = r_o_restart;

`ifndef SYNTHESIS
    // a restart only happens on a nonzero speed
    a_restart_moving: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_pwm_restart |-> o_speed_now != '0)
        else $error("pwm restart with zero speed");

    // pins off exactly when the duty is zero
    a_pin_vs_duty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ((o_drive_pin == PIN_OFF) == (o_pulse_width == '0)))
        else $error("drive pin and pulse width disagree");

    // pin B is selected only for negative speed
    a_pin_sign: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_drive_pin == PIN_B |-> o_speed_now < 0)
        else $error("pin B without negative speed");

    // a held input transaction stays in the input register
    a_hold_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |=> r_in_valid)
        else $error("input transaction lost while stalled");

    // a moving pass never overwrites a pending result
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance |-> (!r_out_valid || !i_stall))
        else $error("result overwritten while stalled");
`endif

endmodule

/* verif/motor_speed_ramp_controller_test.sv */
`timescale 1ns / 1ps

module motor_speed_ramp_controller_test;

    import mscr_pkg::*;

    localparam int IDLE_LIMIT = 2000;

    // One input transaction
    typedef struct {
        t_kind      kind;
        logic [1:0] chan;
        t_speed     target;
        t_period    period;
        logic       coreless;
        logic       fault;
    } t_motor_cmd;

    // One result transaction
    typedef struct {
        logic [1:0] chan;
        t_speed     speed;
        logic [1:0] pin;
        logic [7:0] width;
        logic       clk_sel;
        logic       restart;
    } t_drive_state;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_valid = 1'b0;
    logic       o_stall;
    logic       i_kind = 1'b0;
    logic [1:0] i_channel = '0;
    t_speed     i_target_speed = '0;
    t_period    i_ramp_period = '0;
    logic       i_coreless_flag = 1'b0;
    logic       i_fault_active = 1'b0;
    logic       o_valid;
    logic       i_stall = 1'b0;
    logic [1:0] o_out_channel;
    t_speed     o_speed_now;
    logic [1:0] o_drive_pin;
    logic [7:0] o_pulse_width;
    logic       o_clock_select;
    logic       o_pwm_restart;

    motor_speed_ramp_controller DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_kind          (i_kind),
        .i_channel       (i_channel),
        .i_target_speed  (i_target_speed),
        .i_ramp_period   (i_ramp_period),
        .i_coreless_flag (i_coreless_flag),
        .i_fault_active  (i_fault_active),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_out_channel   (o_out_channel),
        .o_speed_now     (o_speed_now),
        .o_drive_pin     (o_drive_pin),
        .o_pulse_width   (o_pulse_width),
        .o_clock_select  (o_clock_select),
        .o_pwm_restart   (o_pwm_restart)
    );

    // Per-channel copy of the ramp state
    t_speed     chan_speed   [CHANNELS];
    t_speed     chan_target  [CHANNELS];
    t_period    chan_period  [CHANNELS];
    logic       chan_type_req[CHANNELS];
    t_run       chan_type_run[CHANNELS];
    t_period    chan_ticks   [CHANNELS];

    t_drive_state drive_expected[$];
    int           mismatches = 0;
    bit           no_idle = 1'b0;
    int           stall_left = 0;
    int           idle_cycles = 0;

    // Clock
    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Set a new speed on a channel; returns 1 when the PWM is (re)started
    function automatic bit set_speed(int ch, t_speed s, logic ty);
        bit restart = 1'b0;
        chan_type_req[ch] = ty;
        if (s != 0) begin
            if (chan_speed[ch] == 0 || {1'b0, ty} != chan_type_run[ch]) begin
                restart = 1'b1;
                chan_type_run[ch] = {1'b0, ty};
            end
        end
        chan_speed[ch] = s;
        return restart;
    endfunction

    // Predict the result of one accepted transaction and advance the state
    function automatic t_drive_state motor_step(t_motor_cmd c);
        t_drive_state r;
        int  ch = c.chan;
        bit  restart = 1'b0;
        bit  settled;
        int  sv;
        if (c.kind == KIND_REQ) begin
            chan_target[ch]   = c.target;
            chan_period[ch]   = c.period;
            chan_type_req[ch] = c.coreless;
            if (!c.fault) begin
                if (c.period == 0)
                    restart = set_speed(ch, c.target, c.coreless);
                else if (chan_speed[ch] == chan_target[ch] &&
                         {1'b0, chan_type_req[ch]} != chan_type_run[ch])
                    restart = set_speed(ch, chan_speed[ch], chan_type_req[ch]);
            end
        end else begin
            settled = chan_speed[ch] == chan_target[ch] &&
                      {1'b0, chan_type_req[ch]} == chan_type_run[ch];
            if (!settled && !c.fault) begin
                if (chan_ticks[ch] >= chan_period[ch]) begin
                    chan_ticks[ch] = '0;
                    if (chan_speed[ch] < chan_target[ch])
                        restart = set_speed(ch, t_speed'(chan_speed[ch] + 8'sd1),
                                            chan_type_req[ch]);
                    else if (chan_speed[ch] > chan_target[ch])
                        restart = set_speed(ch, t_speed'(chan_speed[ch] - 8'sd1),
                                            chan_type_req[ch]);
                end else begin
                    chan_ticks[ch] = chan_ticks[ch] + 7'd1;
                end
            end
        end
        sv        = chan_speed[ch];
        r.chan    = c.chan;
        r.speed   = chan_speed[ch];
        r.pin     = sv > 0 ? PIN_A : (sv < 0 ? PIN_B : PIN_OFF);
        r.width   = 8'(sv < 0 ? -sv : sv);
        r.clk_sel = chan_type_run[ch] == RUN_NONE ? 1'b0 : chan_type_run[ch][0];
        r.restart = restart;
        return r;
    endfunction

    // Random idle length: mostly none or short, now and then long
    function automatic int pick_gap();
        int r;
        if (no_idle)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(4, 40);
    endfunction

    // Random transaction; requests mostly aim near the current speed so ramps finish
    function automatic t_motor_cmd rand_cmd();
        t_motor_cmd c;
        int         pick = $urandom_range(0, 99);
        int         t;
        c.chan     = 2'($urandom_range(0, CHANNELS - 1));
        c.target   = t_speed'($urandom_range(0, 255));
        c.period   = t_period'($urandom_range(0, 127));
        c.coreless = 1'($urandom_range(0, 1));
        c.fault    = $urandom_range(0, 99) < 5;
        if (pick < 22) begin
            c.kind = KIND_REQ;
            pick = $urandom_range(0, 99);
            if (pick < 30)
                c.period = '0;
            else if (pick < 85)
                c.period = t_period'($urandom_range(1, 3));
            if ($urandom_range(0, 99) < 60) begin
                t = int'(chan_speed[c.chan]) + $urandom_range(0, 40) - 20;
                if (t > 127)
                    t = 127;
                if (t < -128)
                    t = -128;
                c.target = t_speed'(t);
            end
        end else begin
            c.kind = KIND_TICK;
        end
        return c;
    endfunction

    task automatic report_mismatch(string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        mismatches++;
    endtask

    task automatic check_field(string name, int want, int got);
        if (want != got)
            report_mismatch($sformatf("%s expected %0d got %0d", name, want, got));
    endtask

    // Send one transaction and record its expected result on acceptance
    task automatic send_cmd(t_motor_cmd c);
        int gap = pick_gap();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid         <= 1'b1;
        i_kind          <= c.kind;
        i_channel       <= c.chan;
        i_target_speed  <= c.target;
        i_ramp_period   <= c.period;
        i_coreless_flag <= c.coreless;
        i_fault_active  <= c.fault;
        @(posedge i_clk);
        while (o_stall)
            @(posedge i_clk);
        drive_expected.push_back(motor_step(c));
    endtask

    task automatic request(int ch, int tgt, int per, bit ty, bit flt);
        t_motor_cmd c;
        c.kind     = KIND_REQ;
        c.chan     = 2'(ch);
        c.target   = t_speed'(tgt);
        c.period   = t_period'(per);
        c.coreless = ty;
        c.fault    = flt;
        send_cmd(c);
    endtask

    task automatic tick(int ch, bit flt);
        t_motor_cmd c;
        c.kind     = KIND_TICK;
        c.chan     = 2'(ch);
        c.target   = t_speed'($urandom_range(0, 255));
        c.period   = t_period'($urandom_range(0, 127));
        c.coreless = 1'($urandom_range(0, 1));
        c.fault    = flt;
        send_cmd(c);
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        while (drive_expected.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic reset_block();
        for (int i = 0; i < CHANNELS; i++) begin
            chan_speed[i]    = '0;
            chan_target[i]   = '0;
            chan_period[i]   = '0;
            chan_type_req[i] = 1'b0;
            chan_type_run[i] = RUN_NONE;
            chan_ticks[i]    = '0;
        end
        i_rst_n <= 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
    endtask

    // Edge cases: start, stop, type changes, faults, extreme speeds and periods
    task automatic test_directed();
        tick(3, 1'b0);                  // never started: clock select stays 0
        request(0, 127, 0, 1'b1, 1'b0); // immediate full forward, slow clock
        request(1, -128, 0, 1'b0, 1'b0);// immediate full reverse
        request(0, 127, 5, 1'b0, 1'b0); // type change at target re-clocks
        request(0, 0, 0, 1'b0, 1'b0);   // stop keeps the running type
        request(2, 0, 3, 1'b1, 1'b0);   // type change at speed zero
        tick(2, 1'b0);
        tick(2, 1'b0);
        request(2, 3, 1, 1'b1, 1'b0);
        repeat (4) tick(2, 1'b0);
        request(2, -2, 1, 1'b0, 1'b0);  // type change while ramping
        repeat (3) tick(2, 1'b0);
        request(1, 100, 0, 1'b1, 1'b1); // fault on request: stored, speed held
        tick(1, 1'b1);                  // fault on tick: counter holds
        tick(1, 1'b0);
        request(3, -1, 127, 1'b1, 1'b0);// longest period
        tick(3, 1'b0);
        tick(3, 1'b0);
        request(3, -128, 0, 1'b1, 1'b0);
    endtask

    // Long random run with ramps that mostly reach their targets
    task automatic test_random_ramps(int count);
        repeat (count) send_cmd(rand_cmd());
    endtask

    // Sender holds off until every result has drained, then resumes
    task automatic test_drain_pause();
        repeat (60) send_cmd(rand_cmd());
        wait_drained();
        repeat (60) send_cmd(rand_cmd());
    endtask

    // Back-to-back transactions with no idling on either side
    task automatic test_back_to_back();
        no_idle = 1'b1;
        repeat (150) send_cmd(rand_cmd());
        no_idle = 1'b0;
    endtask

    // Result checker and random stall on the result side
    always @(posedge i_clk) begin
        t_drive_state e;
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                if (drive_expected.size() == 0) begin
                    report_mismatch($sformatf("unexpected result on channel %0d",
                                              o_out_channel));
                end else begin
                    e = drive_expected.pop_front();
                    check_field("out_channel", e.chan, o_out_channel);
                    check_field("speed_now", int'(e.speed), int'(o_speed_now));
                    check_field("drive_pin", e.pin, o_drive_pin);
                    check_field("pulse_width", e.width, o_pulse_width);
                    check_field("clock_select", e.clk_sel, o_clock_select);
                    check_field("pwm_restart", e.restart, o_pwm_restart);
                end
            end
            if (stall_left > 0) begin
                stall_left <= stall_left - 1;
                i_stall    <= 1'b1;
            end else begin
                stall_left <= pick_gap();
                i_stall    <= 1'b0;
            end
        end
    end

    // Watchdog on cycles with no transaction on either side
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || !i_rst_n) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("[%0t] timeout: no transaction for %0d cycles", $time, IDLE_LIMIT);
            $display("RESULT: ERROR");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        reset_block();
        test_directed();
        test_random_ramps(1400);
        test_drain_pause();
        test_back_to_back();
        wait_drained();
        repeat (10) @(posedge i_clk);
        if (mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

/* sim.f */
sv/mscr_pkg.sv
sv/motor_speed_ramp_controller.sv
verif/motor_speed_ramp_controller_test.sv
